// File: hw/rtl/ilp_pkg.sv
// types, constants and character codes shared by the integer literal parser
package ilp_pkg;

  localparam int VALUE_BITS = 64;
  localparam int ACC_W      = VALUE_BITS;
  localparam int EXT_W      = ACC_W + 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 2);
  localparam int OUT_W      = 64;
  localparam int CH_W       = 8;

  localparam logic [ACC_W-1:0] MIN_MAG = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] MAX_POS = ~MIN_MAG;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_1     = 8'h31;
  localparam logic [CH_W-1:0] CH_7     = 8'h37;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LB    = 8'h62;
  localparam logic [CH_W-1:0] CH_LC    = 8'h63;
  localparam logic [CH_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_BODY,
    PH_BIN_STOP
  } phase_t;

  typedef enum logic [1:0] {
    RM_DEC,
    RM_HEX,
    RM_BIN,
    RM_OCT
  } radix_t;

  typedef struct packed {
    phase_t             phase;
    radix_t             radix;
    logic               negative;
    logic [ACC_W-1:0]   accum;
    logic [CNT_W-1:0]   bin_digits;
    logic               failed;
    logic               fail_sat;
  } ilp_state_t;

  localparam ilp_state_t ST_RESET = '{
    phase:      PH_START,
    radix:      RM_DEC,
    negative:   1'b0,
    accum:      '0,
    bin_digits: '0,
    failed:     1'b0,
    fail_sat:   1'b0
  };

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } ilp_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             ok;
  } ilp_result_t;

endpackage

// File: hw/rtl/integer_literal_parser.sv
// integer literal parser: one character per transfer in, one value per literal out
// a literal's last character is held in the input register, and its value is then loaded into the result register
// throughput: 1 character per cycle while no last character waits; set by the state update in ilp_engine
// a last character waits in the input register only while the result register is full
// reset (rst_n low, synchronous) returns the parser to start of literal and empties
// both the input and the result register
module integer_literal_parser (
  input  logic        clk,
  input  logic        rst_n,
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last character of the literal
  // parsed values
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [0:0]  out_tuser   // [0] ok
);

  ilp_pkg::ilp_item_t   in_item, item;
  ilp_pkg::ilp_result_t res, out_res;
  logic                 item_valid, advance, res_valid, out_free;

  assign in_item.ch   = in_tdata;
  assign in_item.last = in_tlast;

  // a non-last character never waits; a last one needs room in the result register
  assign advance = item_valid && (!item.last || out_free);

  ilp_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .item_valid(item_valid),
    .item      (item)
  );

  // state update for the held character, result on the last one
  ilp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  ilp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res      (res),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .free     (out_free),
    .out_res  (out_res)
  );

  assign out_tdata    = out_res.value;
  assign out_tuser[0] = out_res.ok;

endmodule

// File: hw/rtl/ilp_in_reg.sv
// input register stage for the character stream
module ilp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilp_pkg::ilp_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output ilp_pkg::ilp_item_t item
);

  logic               valid_r;
  ilp_pkg::ilp_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: hw/rtl/ilp_engine.sv
// parse state registers with the per-character update and the end-of-literal result
module ilp_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ilp_pkg::ilp_item_t   item,
  output logic                 res_valid,
  output ilp_pkg::ilp_result_t res
);

  ilp_pkg::ilp_state_t st_r, st_nxt, upd, body;
  logic                       empty;
  logic [ilp_pkg::CH_W-1:0]   c, lc;
  logic                       is_num, is_oct, is_lhex, is_uhex, d_ok, is_ws;
  logic [3:0]                 d;
  logic [ilp_pkg::EXT_W-1:0]  acc_x, mul, cand, lim_x;
  logic [ilp_pkg::ACC_W-1:0]  lim, sat, sgn, val;
  logic                       ok;

  assign c = item.ch;

  // digit decode
  always_comb begin
    is_num  = (c >= ilp_pkg::CH_0) && (c <= ilp_pkg::CH_9);
    is_oct  = (c >= ilp_pkg::CH_0) && (c <= ilp_pkg::CH_7);
    is_lhex = (c >= ilp_pkg::CH_LA) && (c <= ilp_pkg::CH_LF);
    is_uhex = (c >= ilp_pkg::CH_UA) && (c <= ilp_pkg::CH_UF);
    d       = is_num ? c[3:0] : c[3:0] + 4'd9;
    case (st_r.radix)
      ilp_pkg::RM_HEX: d_ok = is_num || is_lhex || is_uhex;
      ilp_pkg::RM_OCT: d_ok = is_oct;
      default:         d_ok = is_num;
    endcase
    is_ws = (c == ilp_pkg::CH_SPACE) || ((c >= ilp_pkg::CH_TAB) && (c <= ilp_pkg::CH_CR));
    lc    = ((c >= ilp_pkg::CH_UA) && (c <= ilp_pkg::CH_UZ)) ? (c | ilp_pkg::CASE_BIT) : c;
  end

  // shift-add multiply by the radix and exact range check
  always_comb begin
    acc_x = ilp_pkg::EXT_W'(st_r.accum);
    case (st_r.radix)
      ilp_pkg::RM_HEX: mul = acc_x << 4;
      ilp_pkg::RM_OCT: mul = acc_x << 3;
      default:         mul = (acc_x << 3) + (acc_x << 1);
    endcase
    cand  = mul + ilp_pkg::EXT_W'(d);
    lim   = st_r.negative ? ilp_pkg::MIN_MAG : ilp_pkg::MAX_POS;
    lim_x = ilp_pkg::EXT_W'(lim);
  end

  // one body character
  always_comb begin
    body = st_r;
    if (c != ilp_pkg::CH_UNDER) begin
      if (st_r.radix == ilp_pkg::RM_BIN) begin
        if ((c == ilp_pkg::CH_0) || (c == ilp_pkg::CH_1)) begin
          if (st_r.bin_digits <= ilp_pkg::CNT_W'(ilp_pkg::VALUE_BITS)) begin
            body.accum      = {st_r.accum[ilp_pkg::ACC_W-2:0], c[0]};
            body.bin_digits = st_r.bin_digits + 1'b1;
          end
        end else begin
          body.phase = ilp_pkg::PH_BIN_STOP;
        end
      end else if (!d_ok) begin
        body.failed   = 1'b1;
        body.fail_sat = 1'b0;
      end else if (cand > lim_x) begin
        body.failed   = 1'b1;
        body.fail_sat = 1'b1;
      end else begin
        body.accum = cand[ilp_pkg::ACC_W-1:0];
      end
    end
  end

  // phase update
  always_comb begin
    upd   = st_r;
    empty = 1'b0;
    if (!st_r.failed) begin
      case (st_r.phase)
        ilp_pkg::PH_START, ilp_pkg::PH_SIGNED: begin
          if ((st_r.phase == ilp_pkg::PH_START) && is_ws) begin
            empty = 1'b1;
          end else if ((st_r.phase == ilp_pkg::PH_START) &&
                       ((c == ilp_pkg::CH_PLUS) || (c == ilp_pkg::CH_MINUS))) begin
            upd.negative = (c == ilp_pkg::CH_MINUS);
            upd.phase    = ilp_pkg::PH_SIGNED;
            empty        = 1'b1;
          end else if (c == ilp_pkg::CH_UNDER) begin
            upd.failed   = 1'b1;
            upd.fail_sat = 1'b0;
          end else if (c == ilp_pkg::CH_0) begin
            upd.phase = ilp_pkg::PH_ZERO;
            upd.accum = '0;
          end else begin
            upd       = body;
            upd.phase = ilp_pkg::PH_BODY;
          end
        end
        ilp_pkg::PH_ZERO: begin
          if (lc == ilp_pkg::CH_LX) begin
            upd.radix = ilp_pkg::RM_HEX;
            upd.accum = '0;
            upd.phase = ilp_pkg::PH_BODY;
            empty     = 1'b1;
          end else if (lc == ilp_pkg::CH_LB) begin
            upd.radix = ilp_pkg::RM_BIN;
            upd.accum = '0;
            upd.phase = ilp_pkg::PH_BODY;
            empty     = 1'b1;
          end else if (lc == ilp_pkg::CH_LC) begin
            upd.radix = ilp_pkg::RM_OCT;
            upd.accum = '0;
            upd.phase = ilp_pkg::PH_BODY;
            empty     = 1'b1;
          end else begin
            upd       = body;
            upd.phase = ilp_pkg::PH_BODY;
          end
        end
        ilp_pkg::PH_BODY: upd = body;
        default:          upd = st_r;
      endcase
    end
  end

  // end-of-literal result from the updated state
  always_comb begin
    sat = upd.negative ? ilp_pkg::MIN_MAG : ilp_pkg::MAX_POS;
    sgn = upd.negative ? (~upd.accum + 1'b1) : upd.accum;
    val = '0;
    ok  = 1'b0;
    if ((c == ilp_pkg::CH_UNDER) || (empty && !upd.failed)) begin
      val = '0;
    end else if (upd.failed) begin
      val = upd.fail_sat ? sat : '0;
    end else if (upd.radix == ilp_pkg::RM_BIN) begin
      if (upd.bin_digits == '0) begin
        val = '0;
      end else if (upd.bin_digits > ilp_pkg::CNT_W'(ilp_pkg::VALUE_BITS)) begin
        val = ilp_pkg::MAX_POS;
      end else if (upd.accum > (upd.negative ? ilp_pkg::MIN_MAG : ilp_pkg::MAX_POS)) begin
        val = sat;
      end else if (upd.phase == ilp_pkg::PH_BIN_STOP) begin
        val = '0;
      end else begin
        val = sgn;
        ok  = 1'b1;
      end
    end else begin
      val = sgn;
      ok  = 1'b1;
    end
    res.value = ilp_pkg::OUT_W'($signed(val));
    res.ok    = ok;
  end

  assign res_valid = step && item.last;

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = item.last ? ilp_pkg::ST_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ilp_pkg::ST_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: hw/rtl/ilp_out_reg.sv
// result register that holds a parsed value until the sink takes it
module ilp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ilp_pkg::ilp_result_t res,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 free,
  output ilp_pkg::ilp_result_t out_res
);

  logic                 valid_r;
  ilp_pkg::ilp_result_t res_r;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign free      = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: hw/rtl/ilp_checker.sv
// port-level checks for the integer literal parser
module ilp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic [1:0] pend_r, pend_nxt;
  logic       lit_in, res_out;

  assign lit_in  = in_tvalid && in_tready && in_tlast;
  assign res_out = out_tvalid && out_tready;

  // literals whose last character was taken but whose value is not yet delivered
  always_comb begin
    pend_nxt = pend_r + 2'(lit_in) - 2'(res_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result without a finished literal");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 && !out_tready |-> !in_tready)
    else $error("input taken with both stages holding a literal");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// File: tb/tb.sv
// self-checking testbench for integer_literal_parser: directed literals, then random traffic
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  // in the directed table these two marks stand for the bytes 8'h00 and 8'hff
  localparam logic [7:0] MARK_NUL = "^";
  localparam logic [7:0] MARK_FF  = "~";

  localparam int RANDOM_CHARS = 800;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AFTER   = 15;   // results seen before the long output hold-off

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  integer_literal_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] ch
    .in_tlast   (in_tlast),    // last character of the literal
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [63:0] value
    .out_tuser  (out_tuser)    // [0] ok
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parsed value of one literal, as the output transfer should carry it
  typedef struct {
    logic [63:0] value;
    bit          ok;
  } parsed_t;

  parsed_t pending_values[$];

  // directed literals; typed = 1 means the expected value is written in the row
  typedef struct {
    string       text;
    bit          typed;
    logic [63:0] value;
    bit          ok;
  } lit_row_t;

  localparam int N_ROWS = 18;
  lit_row_t directed_rows [N_ROWS] = '{
    '{"0",                   1'b1, 64'd0,   1'b1},
    '{"-0x8000000000000000", 1'b1, MIN_MAG, 1'b1},  // most negative value
    '{"0x8000000000000000",  1'b1, MAX_POS, 1'b0},  // positive overflow saturates
    '{"_",                   1'b1, 64'd0,   1'b0},  // lone underscore
    '{"_5",                  1'b1, 64'd0,   1'b0},  // leading underscore
    '{"12_",                 1'b1, 64'd0,   1'b0},  // trailing underscore
    '{" \t-",                1'b1, 64'd0,   1'b0},  // whitespace and sign, no body
    '{"0x",                  1'b1, 64'd0,   1'b0},  // bare prefix
    '{"1~",                  1'b1, 64'd0,   1'b0},  // bad byte 8'hff
    '{"^",                   1'b1, 64'd0,   1'b0},  // bad byte 8'h00
    '{"9z",                  1'b1, 64'd0,   1'b0},  // bad decimal digit
    '{"0c8",                 1'b1, 64'd0,   1'b0},  // bad octal digit
    '{"0b102",               1'b1, 64'd0,   1'b0},  // binary stopped on a bad digit
    '{"0X_1F",               1'b0, 64'd0,   1'b0},  // underscore right after prefix
    '{"-0xaBc",              1'b0, 64'd0,   1'b0},
    '{"0c17",                1'b0, 64'd0,   1'b0},
    '{"+0b1011",             1'b0, 64'd0,   1'b0},
    '{"0_7",                 1'b0, 64'd0,   1'b0}
  };

  // ---------------------------------------------------------------------------
  // parser state as predicted from the accepted characters
  // ---------------------------------------------------------------------------
  phase_t      ph;
  radix_t      rdx;
  bit          neg;
  logic [63:0] acc;
  int          bdig;
  bit          fail;
  bit          fail_sat;   // latched failure gives the limit instead of zero

  function automatic void clear_literal();
    ph       = PH_START;
    rdx      = RM_DEC;
    neg      = 1'b0;
    acc      = '0;
    bdig     = 0;
    fail     = 1'b0;
    fail_sat = 1'b0;
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    int d;
    d = -1;
    if (c >= CH_0 && c <= CH_9) begin
      d = int'(c - CH_0);
      if (rdx == RM_OCT && d >= 8) d = -1;
    end else if (rdx == RM_HEX) begin
      if (c >= CH_LA && c <= CH_LF) d = int'(c - CH_LA) + 10;
      else if (c >= CH_UA && c <= CH_UF) d = int'(c - CH_UA) + 10;
    end
    return d;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int          d;
    logic [63:0] dv;
    logic [63:0] base;
    logic [63:0] lim;
    if (c == CH_UNDER) return;
    if (rdx == RM_BIN) begin
      // binary keeps counting digits past the width, the check comes at the end
      if (c == CH_0 || c == CH_1) begin
        if (bdig <= VALUE_BITS) begin
          acc  = {acc[62:0], c[0]};
          bdig = bdig + 1;
        end
      end else begin
        ph = PH_BIN_STOP;
      end
      return;
    end
    d    = digit_value(c);
    base = (rdx == RM_HEX) ? 64'd16 : (rdx == RM_OCT) ? 64'd8 : 64'd10;
    lim  = neg ? MIN_MAG : MAX_POS;
    if (d < 0) begin
      fail     = 1'b1;
      fail_sat = 1'b0;
      return;
    end
    dv = 64'(d);
    // exact range check: acc * base + d must stay within the limit
    if (acc > (lim - dv) / base) begin
      fail     = 1'b1;
      fail_sat = 1'b1;
      return;
    end
    acc = acc * base + dv;
  endfunction

  function automatic void first_body(input logic [7:0] c);
    if (c == CH_UNDER) begin
      fail     = 1'b1;
      fail_sat = 1'b0;
    end else if (c == CH_0) begin
      ph  = PH_ZERO;
      acc = '0;
    end else begin
      ph = PH_BODY;
      take_digit(c);
    end
  endfunction

  // advance the predicted state by one character; on the last one report the value
  function automatic void parse_char(input logic [7:0] c, input bit last,
                                     output bit done, output parsed_t res);
    bit          empty;
    logic [7:0]  lc;
    logic [63:0] sat;
    empty     = 1'b0;
    done      = 1'b0;
    res.value = '0;
    res.ok    = 1'b0;
    if (!fail) begin
      case (ph)
        PH_START: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            empty = 1'b1;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg   = (c == CH_MINUS);
            ph    = PH_SIGNED;
            empty = 1'b1;
          end else begin
            first_body(c);
          end
        end
        PH_SIGNED: first_body(c);
        PH_ZERO: begin
          lc = (c >= CH_UA && c <= CH_UZ) ? (c | CASE_BIT) : c;
          ph = PH_BODY;
          if (lc == CH_LX || lc == CH_LB || lc == CH_LC) begin
            rdx   = (lc == CH_LX) ? RM_HEX : (lc == CH_LB) ? RM_BIN : RM_OCT;
            acc   = '0;
            empty = 1'b1;
          end else begin
            take_digit(c);
          end
        end
        PH_BODY: take_digit(c);
        default: ;
      endcase
    end
    if (!last) return;
    done = 1'b1;
    // the two's complement of the smallest magnitude is the pattern itself
    sat  = neg ? MIN_MAG : MAX_POS;
    if (c == CH_UNDER || (empty && !fail)) begin
      res.value = '0;
    end else if (fail) begin
      res.value = fail_sat ? sat : '0;
    end else if (rdx == RM_BIN) begin
      if (bdig == 0) res.value = '0;
      else if (bdig > VALUE_BITS) res.value = MAX_POS;
      else if (acc > (neg ? MIN_MAG : MAX_POS)) res.value = sat;
      else if (ph == PH_BIN_STOP) res.value = '0;
      else begin
        res.value = neg ? (64'd0 - acc) : acc;
        res.ok    = 1'b1;
      end
    end else begin
      res.value = neg ? (64'd0 - acc) : acc;
      res.ok    = 1'b1;
    end
    clear_literal();
  endfunction

  // ---------------------------------------------------------------------------
  // random literal builder
  // ---------------------------------------------------------------------------
  logic [7:0] lit_chars[$];

  function automatic void build_literal();
    int          r;
    int          i;
    radix_t      rx;
    logic [63:0] v;
    string       digs;
    logic [7:0]  c;
    lit_chars.delete();
    // leading whitespace now and then
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 5);
        lit_chars.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
      end
    end
    r = $urandom_range(0, 2);
    if (r == 0) lit_chars.push_back(CH_MINUS);
    else if (r == 1) lit_chars.push_back(CH_PLUS);
    rx = radix_t'($urandom_range(0, 3));
    if (rx != RM_DEC) begin
      c = (rx == RM_HEX) ? CH_LX : (rx == RM_BIN) ? CH_LB : CH_LC;
      if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
      lit_chars.push_back(CH_0);
      lit_chars.push_back(c);
    end
    // about a third of the literals sit on or just past the range limits
    case ($urandom_range(0, 15))
      0: v = MAX_POS;
      1: v = MIN_MAG;
      2: v = MAX_POS - 64'd1;
      3: v = MIN_MAG + 64'd1;
      4: v = '1;
      default: begin
        v = {$urandom, $urandom};
        v = v >> ($urandom_range(0, 1) ? $urandom_range(40, 63) : $urandom_range(0, 63));
      end
    endcase
    case (rx)
      RM_HEX:  digs = $sformatf("%0h", v);
      RM_BIN:  digs = $sformatf("%0b", v);
      RM_OCT:  digs = $sformatf("%0o", v);
      default: digs = $sformatf("%0d", v);
    endcase
    // extra leading zeros count as binary digits and can push past the width
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) digs = {"0", digs};
    end
    for (i = 0; i < digs.len(); i++) begin
      c = digs[i];
      if (c >= CH_LA && c <= CH_LF && $urandom_range(0, 1)) c = c & ~CASE_BIT;
      lit_chars.push_back(c);
      if (i < digs.len() - 1 && $urandom_range(0, 5) == 0) lit_chars.push_back(CH_UNDER);
    end
    // broken literals: bad byte, stray or trailing underscore, cut short, pure noise
    case ($urandom_range(0, 15))
      0: lit_chars[$urandom_range(0, lit_chars.size() - 1)] = 8'($urandom_range(0, 255));
      1: lit_chars.insert($urandom_range(0, lit_chars.size()), CH_UNDER);
      2: lit_chars.push_back(CH_UNDER);
      3: lit_chars = lit_chars[0:$urandom_range(0, lit_chars.size() - 1)];
      4: begin
        lit_chars.delete();
        repeat ($urandom_range(1, 4)) lit_chars.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one character per transfer, random gaps, bursts with no gaps
  // ---------------------------------------------------------------------------
  int errors       = 0;
  int chars_sent   = 0;
  int lits_sent    = 0;
  int results_seen = 0;
  int ok_seen      = 0;
  bit snd_burst    = 1'b0;

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input logic [63:0] tval, input bit tok);
    int      gap;
    bit      done;
    parsed_t res;
    gap = snd_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    // transfer taken at this edge
    chars_sent++;
    parse_char(c, last, done, res);
    if (done) begin
      if (typed) begin
        res.value = tval;
        res.ok    = tok;
      end
      pending_values.push_back(res);
      lits_sent++;
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, bursts, and one long hold-off to back up the input
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    bit rcv_burst;
    bit held;
    rcv_burst  = 1'b0;
    held       = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 9) == 0) rcv_burst = !rcv_burst;
        stall = rcv_burst ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // result checker: every output transfer against the oldest pending value
  parsed_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[0]) ok_seen++;
      if (pending_values.size() == 0) begin
        $error("unexpected result: value %0d ok %0b", $signed(out_tdata), out_tuser[0]);
        errors++;
      end else begin
        want = pending_values.pop_front();
        if (out_tdata !== want.value) begin
          $error("value: expected %0d actual %0d", $signed(want.value), $signed(out_tdata));
          errors++;
        end
        if (out_tuser[0] !== want.ok) begin
          $error("ok: expected %0b actual %0b", want.ok, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         r;
    int         i;
    int         n;
    logic [7:0] c;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    clear_literal();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (r = 0; r < N_ROWS; r++) begin
      n = directed_rows[r].text.len();
      for (i = 0; i < n; i++) begin
        c = directed_rows[r].text[i];
        if (c == MARK_NUL) c = 8'h00;
        else if (c == MARK_FF) c = 8'hff;
        send_char(c, i == n - 1, directed_rows[r].typed,
                  directed_rows[r].value, directed_rows[r].ok);
      end
    end

    // random literals, mostly well formed
    n = chars_sent + RANDOM_CHARS;
    while (chars_sent < n) begin
      if ($urandom_range(0, 3) == 0) snd_burst = !snd_burst;
      build_literal();
      for (i = 0; i < lit_chars.size(); i++)
        send_char(lit_chars[i], i == lit_chars.size() - 1, 1'b0, 64'd0, 1'b0);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain, then keep the clock running to catch anything extra
    while (pending_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d literals in %0d characters, %0d values checked (%0d valid)",
             lits_sent, chars_sent, results_seen, ok_seen);
    $display("summary: output held off once for %0d cycles to stall the input", HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: integer_literal_parser.f
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_in_reg.sv
hw/rtl/ilp_engine.sv
hw/rtl/ilp_out_reg.sv
hw/rtl/integer_literal_parser.sv
hw/rtl/ilp_checker.sv
tb/tb.sv
